// File: rtl/core/page_frame_bitmap_allocator_unit_assert.svh
// Assertion macros shared by the checker modules of the page frame allocator.
// Each macro expects a clock named clk and a synchronous active-high reset rst.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page frame allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page frame allocator: next-cycle check failed");

`endif

// File: rtl/core/pfba_pkg.sv
// Shared constants, operation codes and bit helpers of the page frame allocator.
// No dependencies; used by the top level and by its checker.
package pfba_pkg;

  localparam int MAX_PAGES = 65536;
  localparam int PAGE_W    = 16;
  localparam int CNT_W     = 17;
  localparam int OP_W      = 3;

  // The busy map is held as rows of WORD_W bits.
  localparam int WORD_W  = 32;
  localparam int WORD_SH = $clog2(WORD_W);
  localparam int ROWS    = MAX_PAGES / WORD_W;
  localparam int ROW_AW  = $clog2(ROWS);

  // Stream payload layout.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  localparam logic [OP_W-1:0] OP_LOCK      = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd3;
  localparam logic [OP_W-1:0] OP_REQUEST   = 3'd4;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_PAGES);

  // Number of set bits in one row.
  function automatic logic [WORD_SH:0] popcnt(input logic [WORD_W-1:0] x);
    logic [WORD_SH:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + {{WORD_SH{1'b0}}, x[i]};
    end
    return n;
  endfunction

  // Position of the lowest set bit of one row (zero when none is set).
  function automatic logic [WORD_SH-1:0] low_bit(input logic [WORD_W-1:0] x);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = WORD_SH'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/page_frame_bitmap_allocator_unit.sv
// Page frame bitmap allocator: busy map in a row-wide synchronous memory.
// Depends on pfba_pkg.
//
// A run request walks the rows its range touches; a page request walks rows up
// from the hint row until it finds a clear page or reaches the bound. One
// row of 32 pages is read and written back per cycle, set by the single memory
// read port. Empty runs and unknown operations skip the row walk. One request
// is worked on at a time: no request is taken until the last result is
// published. After reset a clearing pass zeroes the busy map; no request is
// accepted during it, configuration writes are taken.
module page_frame_bitmap_allocator_unit
  import pfba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Request channel.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // first_page[15:0], page_count[32:16]
  input  logic [OP_W-1:0]       s_tuser,   // op[2:0]
  // Result channel.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // page_index[15:0], free_pages[32:16], used_pages[49:33], reserved_pages[66:50]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,   // page_found[0]
  // Configuration: page_limit.
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;

  // Busy map: one bit per page, WORD_W pages per row.
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] mem_q;

  // Architectural state.
  logic [CNT_W-1:0] page_limit;
  logic [CNT_W-1:0] hint;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] reserved;

  // Per-request context: operation and inclusive page range.
  logic [OP_W-1:0]   op_q;
  logic [PAGE_W-1:0] lo_q;
  logic [PAGE_W-1:0] last_q;
  logic              found;
  logic [PAGE_W-1:0] found_idx;

  // Row streaming: rd_row is the next row to read, proc_row the row whose data
  // sits in mem_q this cycle.
  logic [ROW_AW-1:0] clr_row;
  logic [ROW_AW-1:0] rd_row;
  logic              rd_more;
  logic [ROW_AW-1:0] proc_row;
  logic              proc_vld;

  // The addressable bound is the smaller of page_limit and the map size.
  logic [CNT_W-1:0] lim;
  assign lim = (page_limit < LIMIT_RESET) ? page_limit : LIMIT_RESET;

  assign s_tready = (state == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Acceptance: turn the request into a page range, or mark it as having no
  // work. A page request covers the hint up to the bound.
  // ---------------------------------------------------------------------------
  logic [OP_W-1:0]   in_op;
  logic [PAGE_W-1:0] in_first;
  logic [CNT_W-1:0]  in_count;
  logic [CNT_W:0]    run_sum;
  logic [CNT_W-1:0]  run_end;
  logic [PAGE_W-1:0] acc_lo;
  logic [CNT_W-1:0]  acc_end;
  logic [CNT_W-1:0]  acc_last;
  logic              acc_empty;

  assign in_op    = s_tuser;
  assign in_first = s_tdata[PAGE_W-1:0];
  assign in_count = s_tdata[PAGE_W+CNT_W-1:PAGE_W];

  always_comb begin
    run_sum = {2'b00, in_first} + {1'b0, in_count};
    run_end = (run_sum < {1'b0, lim}) ? run_sum[CNT_W-1:0] : lim;
    case (in_op)
      OP_LOCK, OP_FREE, OP_RESERVE, OP_UNRESERVE: begin
        acc_lo    = in_first;
        acc_end   = run_end;
        acc_empty = (run_end <= {1'b0, in_first});
      end
      OP_REQUEST: begin
        acc_lo    = hint[PAGE_W-1:0];
        acc_end   = lim;
        acc_empty = (hint >= lim);
      end
      default: begin
        acc_lo    = '0;
        acc_end   = CNT_W'(1);
        acc_empty = 1'b1;
      end
    endcase
    acc_last = acc_end - CNT_W'(1);
  end

  // ---------------------------------------------------------------------------
  // Row update: mask the row to the pages of the range, then set or clear.
  // ---------------------------------------------------------------------------
  logic [WORD_SH-1:0] hi_sh;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  chg;
  logic [WORD_W-1:0]  avail;
  logic [WORD_SH-1:0] pos;
  logic [WORD_SH:0]   pc;
  logic [CNT_W-1:0]   delta;
  logic [PAGE_W-1:0]  cleared_pg;
  logic               last_row;

  logic               wr_en;
  logic [ROW_AW-1:0]  wr_row;
  logic [WORD_W-1:0]  wr_data;
  logic [CNT_W-1:0]   used_next;
  logic [CNT_W-1:0]   reserved_next;
  logic [CNT_W-1:0]   hint_next;
  logic               hit;
  logic               stop;

  always_comb begin
    hi_sh    = ~last_q[WORD_SH-1:0];
    lo_mask  = (proc_row == lo_q[PAGE_W-1:WORD_SH]) ?
               ({WORD_W{1'b1}} << lo_q[WORD_SH-1:0]) : {WORD_W{1'b1}};
    hi_mask  = (proc_row == last_q[PAGE_W-1:WORD_SH]) ?
               ({WORD_W{1'b1}} >> hi_sh) : {WORD_W{1'b1}};
    mask     = lo_mask & hi_mask;
    last_row = (proc_row == last_q[PAGE_W-1:WORD_SH]);

    if (op_q == OP_LOCK || op_q == OP_RESERVE) begin
      chg = mask & ~mem_q;
    end else begin
      chg = mask & mem_q;
    end
    avail      = mask & ~mem_q;
    pc         = popcnt(chg);
    delta      = {{(CNT_W-WORD_SH-1){1'b0}}, pc};
    pos        = (op_q == OP_REQUEST) ? low_bit(avail) : low_bit(chg);
    cleared_pg = {proc_row, pos};

    wr_en         = 1'b0;
    wr_row        = proc_row;
    wr_data       = mem_q;
    used_next     = used;
    reserved_next = reserved;
    hint_next     = hint;
    hit           = 1'b0;
    stop          = 1'b0;

    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_row  = clr_row;
      wr_data = '0;
    end else if (state == ST_RUN && proc_vld) begin
      case (op_q)
        OP_LOCK: begin
          wr_en     = 1'b1;
          wr_data   = mem_q | chg;
          used_next = used + delta;
          stop      = last_row;
        end
        OP_RESERVE: begin
          wr_en         = 1'b1;
          wr_data       = mem_q | chg;
          reserved_next = reserved + delta;
          stop          = last_row;
        end
        OP_FREE, OP_UNRESERVE: begin
          wr_en   = 1'b1;
          wr_data = mem_q & ~chg;
          if (op_q == OP_FREE) begin
            used_next = used - delta;
          end else begin
            reserved_next = reserved - delta;
          end
          // Rows go upward, so the first cleared page below the hint is the lowest.
          if (chg != '0 && hint > {1'b0, cleared_pg}) begin
            hint_next = {1'b0, cleared_pg};
          end
          stop = last_row;
        end
        OP_REQUEST: begin
          if (avail != '0) begin
            wr_en     = 1'b1;
            wr_data   = mem_q | (WORD_W'(1) << pos);
            used_next = used + CNT_W'(1);
            hint_next = {1'b0, cleared_pg};
            hit       = 1'b1;
            stop      = 1'b1;
          end else if (last_row) begin
            // Nothing free up to the bound: the hint parks there.
            hint_next = lim;
            stop      = 1'b1;
          end
        end
        default: begin
          stop = 1'b1;
        end
      endcase
    end
  end

  // Memory: one write port, one registered read port. Within a run the row
  // written is always one below the row read, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    mem_q <= mem[rd_row];
  end

  // ---------------------------------------------------------------------------
  // Control.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      page_limit <= LIMIT_RESET;
      hint       <= '0;
      used       <= '0;
      reserved   <= '0;
      rd_more    <= 1'b0;
      proc_vld   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_limit <= cfg_wdata;
      end
      // In ST_DONE the publish branch below owns the valid flag.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + ROW_AW'(1);
          if (clr_row == ROW_AW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op_q      <= in_op;
            lo_q      <= acc_lo;
            last_q    <= acc_last[PAGE_W-1:0];
            rd_row    <= acc_lo[PAGE_W-1:WORD_SH];
            found     <= 1'b0;
            found_idx <= '0;
            proc_vld  <= 1'b0;
            rd_more   <= !acc_empty;
            state     <= acc_empty ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          used     <= used_next;
          reserved <= reserved_next;
          hint     <= hint_next;
          if (hit) begin
            found     <= 1'b1;
            found_idx <= cleared_pg;
          end
          if (stop) begin
            rd_more  <= 1'b0;
            proc_vld <= 1'b0;
            state    <= ST_DONE;
          end else begin
            proc_vld <= rd_more;
            proc_row <= rd_row;
            if (rd_more) begin
              rd_row  <= rd_row + ROW_AW'(1);
              rd_more <= (rd_row != last_q[PAGE_W-1:WORD_SH]);
            end
          end
        end
        ST_DONE: begin
          // Wait for the output register to be free, then publish the result.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= found;
            m_tdata  <= {5'b0, reserved, used, page_limit - used - reserved, found_idx};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/pfba_chk.sv
// Port-level checker for the page frame allocator, bound to its top level.
// Depends on pfba_pkg and page_frame_bitmap_allocator_unit_assert.svh.
`include "page_frame_bitmap_allocator_unit_assert.svh"

module pfba_chk
  import pfba_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,   // first_page[15:0], page_count[32:16]
  input logic [OP_W-1:0]       s_tuser,   // op[2:0]
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,   // index, free, used, reserved
  input logic                  m_tuser,   // page_found[0]
  input logic                  cfg_we,
  input logic [CNT_W-1:0]      cfg_wdata
);

  // Copy of page_limit as seen on the configuration port.
  logic [CNT_W-1:0] limit_seen;
  logic [CNT_W-1:0] free_expect;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_seen <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_seen <= cfg_wdata;
    end
  end

  assign free_expect = limit_seen - m_tdata[49:33] - m_tdata[66:50];

  // A stalled result keeps its contents.
  `PFBA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // Only one request is worked on at a time.
  `PFBA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
  // Free pages are the limit less used and reserved pages.
  `PFBA_ASSERT_SAME(a_free_sum, m_tvalid, m_tdata[32:16] == free_expect)
  // Without a granted page the index reads zero.
  `PFBA_ASSERT_SAME(a_idx_zero, m_tvalid && !m_tuser, m_tdata[15:0] == 16'd0)

endmodule

bind page_frame_bitmap_allocator_unit pfba_chk u_pfba_chk (.*);

// File: tb/sv/page_frame_bitmap_allocator_unit_tb.sv
// Self-checking bench for the page frame bitmap allocator: run, request and page_limit traffic
// on the stream ports, with results checked against an in-bench allocator model.
// Depends on pfba_pkg and on the page_frame_bitmap_allocator_unit RTL.
module page_frame_bitmap_allocator_unit_tb;
  import pfba_pkg::*;

  // Operation codes 5 to 7 are undefined; the block must leave its state alone for them.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  // A full-map page request scans 2048 rows and the clearing pass after reset walks
  // all 2048 rows, so long stretches without traffic are normal. This is well beyond that.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES  = 6;
  localparam int OPS_PER_PHASE  = 330;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  count;
  } page_op_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] index;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } page_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // first_page[15:0], page_count[32:16]
  logic [OP_W-1:0]       s_tuser = '0;   // op[2:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // page_index, free, used, reserved pages
  logic                  m_tuser;        // page_found[0]
  logic                  cfg_we = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  page_frame_bitmap_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and results predicted for requests already taken.
  page_op_t     pending_ops[$];
  page_result_t expected_results[$];

  // Allocator model: one busy bit per page, next-fit hint, counters and the limit register.
  bit               busy_bits[MAX_PAGES];
  logic [CNT_W-1:0] hint_model;
  logic [CNT_W-1:0] used_model;
  logic [CNT_W-1:0] reserved_model;
  logic [CNT_W-1:0] limit_model;

  // Pacing, in percent of cycles idled by each side; the stimulus process sets them per phase.
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 77;

  // Limit the stimulus side aims its page addresses at.
  logic [CNT_W-1:0] stim_limit = LIMIT_RESET;

  bit          req_taken;
  page_op_t    next_op;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned requests_done;
  int unsigned pages_granted;
  int unsigned request_misses;
  int unsigned limit_writes;

  // Pages are addressable only below the smaller of page_limit and the map size.
  function automatic int unsigned page_bound(input logic [CNT_W-1:0] lim);
    return (lim < MAX_PAGES) ? int'(lim) : MAX_PAGES;
  endfunction

  // Applies one request to the model and returns the result the block must report.
  function automatic page_result_t apply_page_op(input logic [OP_W-1:0]   op,
                                                 input logic [PAGE_W-1:0] first,
                                                 input logic [CNT_W-1:0]  count);
    page_result_t res;
    int unsigned  lim;
    int unsigned  p;
    int unsigned  h;
    res = '0;
    lim = page_bound(limit_model);
    if (op <= OP_UNRESERVE) begin
      // Runs stop at the bound; setting a set bit or clearing a clear one is a no-op.
      // The bit does not remember whether a lock or a reserve set it.
      for (int unsigned i = 0; i < count; i++) begin
        p = first + i;
        if (p >= lim) begin
          break;
        end
        if (op == OP_LOCK || op == OP_RESERVE) begin
          if (!busy_bits[p]) begin
            busy_bits[p] = 1'b1;
            if (op == OP_LOCK) begin
              used_model = used_model + 1'b1;
            end else begin
              reserved_model = reserved_model + 1'b1;
            end
          end
        end else if (busy_bits[p]) begin
          busy_bits[p] = 1'b0;
          if (op == OP_FREE) begin
            used_model = used_model - 1'b1;
          end else begin
            reserved_model = reserved_model - 1'b1;
          end
          if (hint_model > p) begin
            hint_model = p[CNT_W-1:0];
          end
        end
      end
    end else if (op == OP_REQUEST) begin
      // Next-fit: scan up from the hint. A miss parks the hint at the bound, unless
      // it already sat at or above it, in which case nothing moves.
      h = hint_model;
      if (h < lim) begin
        while (h < lim && busy_bits[h]) begin
          h++;
        end
        if (h < lim) begin
          busy_bits[h] = 1'b1;
          used_model = used_model + 1'b1;
          res.found = 1'b1;
          res.index = h[PAGE_W-1:0];
          pages_granted++;
        end else begin
          request_misses++;
        end
        hint_model = h[CNT_W-1:0];
      end else begin
        request_misses++;
      end
    end
    // Free accounting uses the raw register value, not the bound, and wraps at 17 bits.
    res.free_pages     = limit_model - used_model - reserved_model;
    res.used_pages     = used_model;
    res.reserved_pages = reserved_model;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver. A request stays on the bus until it is taken; only then may the sender idle.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || req_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= IN_DATA_W'({next_op.count, next_op.first});
          s_tuser  <= next_op.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor. Samples both channels and the configuration port at the rising edge,
  // predicts each taken request and checks each result against the oldest prediction.
  always @(posedge clk) begin
    page_result_t want;
    req_taken = 1'b0;
    if (rst) begin
      for (int i = 0; i < MAX_PAGES; i++) begin
        busy_bits[i] = 1'b0;
      end
      hint_model     = '0;
      used_model     = '0;
      reserved_model = '0;
      limit_model    = LIMIT_RESET;
      idle_cycles    = 0;
    end else begin
      if (cfg_we) begin
        limit_model = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %h/%0b",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("page_found", want.found, m_tuser);
          check_field("page_index", want.index, m_tdata[15:0]);
          check_field("free_pages", want.free_pages, m_tdata[32:16]);
          check_field("used_pages", want.used_pages, m_tdata[49:33]);
          check_field("reserved_pages", want.reserved_pages, m_tdata[66:50]);
        end
      end
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        requests_done++;
        expected_results.push_back(apply_page_op(s_tuser, s_tdata[15:0], s_tdata[32:16]));
      end
      // Watchdog on cycles with no traffic of any kind.
      if (req_taken || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL page_frame_bitmap_allocator_unit");
        $finish;
      end
    end
  end

  task automatic queue_page_op(input logic [OP_W-1:0] op, input int unsigned first,
                               input int unsigned count);
    pending_ops.push_back('{op, PAGE_W'(first), CNT_W'(count)});
  endtask

  // Blocks until the sender has nothing left and every predicted result has arrived.
  // The check runs just after the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || expected_results.size() != 0 || s_tvalid) begin
      @(negedge clk);
      #1;
    end
  endtask

  task automatic write_page_limit(input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    stim_limit = CNT_W'(value);
    limit_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  int unsigned phase_limits[RANDOM_PHASES] = '{256, 65536, 1, 3000, 131071, 64};

  // Stimulus: a directed pass over the corner cases, then random phases, each under its own
  // page_limit. The block is drained before every register write, which also makes the
  // sender wait for all outstanding results.
  initial begin
    int unsigned      sel;
    int unsigned      lim;
    int unsigned      first;
    int unsigned      count;
    logic [OP_W-1:0]  op;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, at the reset limit, which equals the map size.
    queue_page_op(OP_LOCK, 0, 0);              // empty run
    queue_page_op(OP_LOCK, 0, 65536);          // whole map, longest run
    queue_page_op(OP_REQUEST, 0, 0);           // map full: miss, hint parks at the bound
    queue_page_op(OP_LOCK, 65535, 1);          // setting a page that is already set
    queue_page_op(OP_FREE, 65535, 1);          // clearing the top page pulls the hint down
    queue_page_op(OP_REQUEST, 65535, 65536);   // run arguments ignored, grants the top page
    queue_page_op(OP_UNRESERVE, 100, 10);      // unreserving locked pages, reserved wraps
    queue_page_op(OP_RESERVE, 100, 10);
    queue_page_op(OP_FREE, 0, 65536);          // frees reserved pages as used ones
    queue_page_op(OP_FREE, 5, 3);              // clearing pages that are already clear
    queue_page_op(OP_REQUEST, 65535, 65536);   // hint now at zero
    queue_page_op(OP_UNDEF_LO, 7, 9);
    queue_page_op(OP_UNDEF_HI, 65535, 65536);
    queue_page_op(OP_RESERVE, 1000, 4);        // survives the limit being lowered below it
    queue_page_op(OP_LOCK, 65530, 100);        // run that runs off the end of the map
    wait_idle();

    // Lowered limit: runs clip at it and bits above it keep their value.
    write_page_limit(40);
    queue_page_op(OP_LOCK, 30, 20);
    queue_page_op(OP_RESERVE, 1000, 4);
    queue_page_op(OP_LOCK, 0, 30);
    queue_page_op(OP_REQUEST, 0, 0);           // nothing clear below the bound
    queue_page_op(OP_UNRESERVE, 35, 1);        // unreserving a locked page
    queue_page_op(OP_REQUEST, 0, 0);
    wait_idle();

    // Zero limit: nothing is addressable, the hint is already above the bound.
    write_page_limit(0);
    queue_page_op(OP_REQUEST, 0, 0);
    queue_page_op(OP_LOCK, 0, 5);
    wait_idle();

    // All-ones limit: bound is the map size, free accounting still uses the register.
    write_page_limit(131071);
    queue_page_op(OP_FREE, 1000, 4);
    queue_page_op(OP_REQUEST, 0, 0);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Two phases with a slow receiver, two with a slow sender, two at full rate.
      case (ph / 2)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_page_limit(phase_limits[ph]);
      lim = page_bound(stim_limit);
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          op = OP_REQUEST;
        end else if (sel < 55) begin
          op = OP_LOCK;
        end else if (sel < 75) begin
          op = OP_FREE;
        end else if (sel < 85) begin
          op = OP_RESERVE;
        end else if (sel < 97) begin
          op = OP_UNRESERVE;
        end else begin
          op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end
        // Mostly aim inside the bound so runs collide with earlier ones; now and then
        // pick any page so the upper address bits toggle.
        if (lim != 0 && $urandom_range(0, 9) != 0) begin
          first = $urandom_range(0, lim - 1);
        end else begin
          first = $urandom_range(0, MAX_PAGES - 1);
        end
        // Short runs keep the block fast; a few long ones sweep large parts of the map.
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
          count = $urandom_range(0, MAX_PAGES);
        end else if (sel < 6) begin
          count = 0;
        end else begin
          count = $urandom_range(1, 48);
        end
        queue_page_op(op, first, count);
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (16) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, expected_results.size(), expected_results.size());
      error_count++;
    end
    $display("Summary: %0d requests over %0d page_limit settings, %0d pages granted,",
             requests_done, limit_writes + 1, pages_granted);
    $display("  %0d page requests found no clear page, %0d mismatches.",
             request_misses, error_count);
    if (error_count == 0) begin
      $display("PASS page_frame_bitmap_allocator_unit");
    end else begin
      $display("FAIL page_frame_bitmap_allocator_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pfba_pkg.sv
rtl/core/page_frame_bitmap_allocator_unit.sv
rtl/core/pfba_chk.sv
tb/sv/page_frame_bitmap_allocator_unit_tb.sv
